FILE: sv/hrse_pkg.sv
`default_nettype none

package hrse_pkg;

   localparam logic [1:0] OP_CONTINUE    = 2'd0;
   localparam logic [1:0] OP_NEW_SECTION = 2'd1;
   localparam logic [1:0] OP_END         = 2'd2;

   localparam logic [7:0] REC_TYPE_DATA  = 8'h00;
   localparam logic [7:0] REC_TYPE_EOF   = 8'h01;
   localparam logic [7:0] REC_TYPE_ELA   = 8'h04;
   localparam logic [7:0] ELA_COUNT      = 8'd2;

   localparam logic [7:0] CHAR_COLON     = 8'h3A;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;

   localparam logic [4:0] BPR_RESET      = 5'd16;

   typedef enum logic [1:0] {
      REC_NONE,
      REC_DATA,
      REC_ELA,
      REC_EOF
   } rec_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_FLUSH,
      ST_ELA,
      ST_EOF
   } state_type;

   typedef struct packed {
      logic         load;
      rec_kind_type rec_kind;
      logic         rec_last;
      logic         commit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       join_ok;
      logic       has_fill;
      logic       need_ela;
      logic       emit_fire;
      logic       rec_end;
   } status_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = 8'h30 + {4'd0, nib};
      end else begin
         c = 8'h37 + {4'd0, nib};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: sv/hrse_ctrl.sv
`default_nettype none

module hrse_ctrl
   import hrse_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd.load     = 1'b0;
      cmd.rec_kind = REC_NONE;
      cmd.rec_last = 1'b0;
      cmd.commit   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.op == OP_END) begin
               state_in = status.has_fill ? ST_FLUSH : ST_EOF;
            end else if (status.op inside {OP_CONTINUE, OP_NEW_SECTION}) begin
               if (status.join_ok) begin
                  cmd.commit = 1'b1;
                  state_in   = ST_IDLE;
               end else if (status.has_fill) begin
                  state_in = ST_FLUSH;
               end else if (status.need_ela) begin
                  state_in = ST_ELA;
               end else begin
                  cmd.commit = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            cmd.rec_kind = REC_DATA;
            cmd.rec_last = (status.op != OP_END) && !status.need_ela;
            if (status.rec_end) begin
               if (status.op == OP_END) begin
                  state_in = ST_EOF;
               end else if (status.need_ela) begin
                  state_in = ST_ELA;
               end else begin
                  cmd.commit = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         ST_ELA: begin
            cmd.rec_kind = REC_ELA;
            cmd.rec_last = 1'b1;
            if (status.rec_end) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_EOF: begin
            cmd.rec_kind = REC_EOF;
            cmd.rec_last = 1'b1;
            if (status.rec_end) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_load_decides: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_DECIDE)
      else $error("accepted item did not go to decide");

   a_ela_ends_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ELA && status.rec_end) |=> state_ff == ST_IDLE)
      else $error("item continued after address record");

   a_no_emit_in_decide: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DECIDE |-> !status.emit_fire)
      else $error("character emitted while deciding");

endmodule

`default_nettype wire

FILE: sv/hrse_datapath.sv
`default_nettype none

module hrse_datapath
   import hrse_pkg::*;
#(
   parameter int MAX_RECORD_BYTES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output status_type       status,
   input  wire logic [1:0]  req_op,
   input  wire logic [31:0] req_address,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        csr_valid,
   input  wire logic [4:0]  csr_bytes_per_record,
   input  wire logic        rsp_stall,
   output logic             rsp_valid,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_last_char
);

   localparam int FILL_W = $clog2(MAX_RECORD_BYTES + 1);
   localparam int IDX_W  = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
   localparam int CH_W   = $clog2(2 * (MAX_RECORD_BYTES + 5) + 2);
   localparam int BPOS_W = CH_W - 1;
   localparam logic [4:0] MAX_CAP = 5'(MAX_RECORD_BYTES);

   // item under work
   logic [1:0]  op_ff;
   logic [31:0] addr_ff;
   logic [7:0]  byte_ff;

   // record state
   logic [7:0]        bytes_ff [MAX_RECORD_BYTES];
   logic [FILL_W-1:0] fill_ff;
   logic [31:0]       start_ff;
   logic [15:0]       upper_ff;
   logic              sent_ff;
   logic [4:0]        bpr_ff;

   // emitter
   logic [CH_W-1:0] ch_idx_ff;
   logic [7:0]      sum_ff;
   logic            out_valid_ff;
   logic [7:0]      out_char_ff;
   logic            out_last_ff;

   logic [4:0]        cap;
   logic [15:0]       item_upper;
   logic              join_ok;
   logic              need_ela;
   logic [31:0]       next_addr;
   logic [IDX_W-1:0]  wr_idx;

   logic [7:0]        rec_count;
   logic [7:0]        rec_addr_hi;
   logic [7:0]        rec_addr_lo;
   logic [7:0]        rec_type;
   logic [CH_W-1:0]   ch_m1;
   logic [BPOS_W-1:0] bpos;
   logic [7:0]        bpos8;
   logic [7:0]        data_off;
   logic              lo_nib;
   logic              is_colon;
   logic              is_newline;
   logic              is_checksum;
   logic [7:0]        data_val;
   logic [7:0]        cur_byte;
   logic [7:0]        char_in;
   logic              emitting;
   logic              slot_free;
   logic              fire;

   assign cap = (bpr_ff == 5'd0) ? 5'd1 : ((bpr_ff > MAX_CAP) ? MAX_CAP : bpr_ff);
   assign item_upper = addr_ff[31:16];
   assign next_addr  = start_ff + 32'(fill_ff);
   assign join_ok = (op_ff == OP_CONTINUE) && (fill_ff != '0) && (5'(fill_ff) < cap)
                    && (addr_ff == next_addr) && (item_upper == start_ff[31:16]);
   assign need_ela = (item_upper != upper_ff) && ((item_upper != 16'd0) || sent_ff);
   assign wr_idx = join_ok ? fill_ff[IDX_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_op;
         addr_ff <= req_address;
         byte_ff <= req_data_byte;
      end
      if (cmd.commit && (op_ff != OP_END)) begin
         bytes_ff[wr_idx] <= byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         start_ff <= '0;
         upper_ff <= '0;
         sent_ff  <= 1'b0;
      end else if (cmd.commit) begin
         if (op_ff == OP_END) begin
            fill_ff  <= '0;
            start_ff <= '0;
            upper_ff <= '0;
            sent_ff  <= 1'b0;
         end else if (join_ok) begin
            fill_ff <= fill_ff + FILL_W'(1);
         end else begin
            fill_ff  <= FILL_W'(1);
            start_ff <= addr_ff;
            upper_ff <= item_upper;
            if (need_ela) begin
               sent_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpr_ff <= BPR_RESET;
      end else if (csr_valid) begin
         bpr_ff <= csr_bytes_per_record;
      end
   end

   // record fields by kind
   always_comb begin
      rec_count   = 8'd0;
      rec_addr_hi = 8'd0;
      rec_addr_lo = 8'd0;
      rec_type    = REC_TYPE_EOF;
      case (cmd.rec_kind)
         REC_DATA: begin
            rec_count   = 8'(fill_ff);
            rec_addr_hi = start_ff[15:8];
            rec_addr_lo = start_ff[7:0];
            rec_type    = REC_TYPE_DATA;
         end
         REC_ELA: begin
            rec_count = ELA_COUNT;
            rec_type  = REC_TYPE_ELA;
         end
         default: begin
            rec_type = REC_TYPE_EOF;
         end
      endcase
   end

   // char 0 is ':', then two hex chars per byte, then newline
   assign ch_m1       = ch_idx_ff - CH_W'(1);
   assign bpos        = ch_m1[CH_W-1:1];
   assign lo_nib      = ch_m1[0];
   assign bpos8       = 8'(bpos);
   assign data_off    = bpos8 - 8'd4;
   assign is_colon    = (ch_idx_ff == '0);
   assign is_newline  = (8'(ch_idx_ff) == (((rec_count + 8'd5) << 1) + 8'd1));
   assign is_checksum = (bpos8 == (rec_count + 8'd4));

   always_comb begin
      if (cmd.rec_kind == REC_ELA) begin
         data_val = data_off[0] ? item_upper[7:0] : item_upper[15:8];
      end else begin
         data_val = bytes_ff[data_off[IDX_W-1:0]];
      end
   end

   always_comb begin
      case (bpos8)
         8'd0:    cur_byte = rec_count;
         8'd1:    cur_byte = rec_addr_hi;
         8'd2:    cur_byte = rec_addr_lo;
         8'd3:    cur_byte = rec_type;
         default: cur_byte = is_checksum ? (~sum_ff + 8'd1) : data_val;
      endcase
   end

   always_comb begin
      if (is_colon) begin
         char_in = CHAR_COLON;
      end else if (is_newline) begin
         char_in = CHAR_NEWLINE;
      end else begin
         char_in = hex_char(lo_nib ? cur_byte[3:0] : cur_byte[7:4]);
      end
   end

   assign emitting  = (cmd.rec_kind != REC_NONE);
   assign slot_free = !out_valid_ff || !rsp_stall;
   assign fire      = emitting && slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_idx_ff <= '0;
      end else if (fire) begin
         ch_idx_ff <= is_newline ? '0 : ch_idx_ff + CH_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         if (is_colon) begin
            sum_ff <= 8'd0;
         end else if (lo_nib && !is_checksum && !is_newline) begin
            sum_ff <= sum_ff + cur_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_char_ff <= char_in;
         out_last_ff <= cmd.rec_last && is_newline;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_char  = out_char_ff;
   assign rsp_last_char = out_last_ff;

   assign status.op        = op_ff;
   assign status.join_ok   = join_ok;
   assign status.has_fill  = (fill_ff != '0);
   assign status.need_ela  = need_ela;
   assign status.emit_fire = fire;
   assign status.rec_end   = fire && is_newline;

   a_commit_between_records: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (ch_idx_ff == '0) || (fire && is_newline))
      else $error("state committed in the middle of a record");

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= 32'(MAX_RECORD_BYTES))
      else $error("record fill beyond capacity");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && op_ff == OP_END) |=> (fill_ff == '0) && !sent_ff && (upper_ff == '0))
      else $error("end of stream did not clear state");

endmodule

`default_nettype wire

FILE: sv/hex_record_stream_encoder_core.sv
// Intel HEX (I32HEX) text writer.
// req_ channel: op, address, data_byte; a transfer takes place when
// req_valid is high and req_stall is low. Bytes collect into a data record
// of up to csr_bytes_per_record bytes (0 acts as 1, capped at
// MAX_RECORD_BYTES); op 1 forces a new record, op 2 flushes and writes EOF.
// rsp_ channel: one ASCII character per transfer; rsp_last_char marks the
// final character caused by one input item. Items that cause no text
// produce no transfer.
// Timing: an item is decided in the cycle after its transfer. A byte that
// joins the open record is committed in the decide state; otherwise the
// record sequencer emits one character per cycle while rsp_ is not stalled
// (12 + 2 * count per data record, 16 for an address record, 12 for EOF).
// The first character reaches rsp_ through the output register.
// A stalled rsp_ holds its character and freezes the sequencer; the single
// output register lets the next item be taken while the last character waits.
// Reset clears the open record, the address state and sets the record
// length register to 16. csr_ writes are taken at any time (ready is tied
// high) and should be issued only while the block is idle.
`default_nettype none

module hex_record_stream_encoder_core
   import hrse_pkg::*;
#(
   parameter int MAX_RECORD_BYTES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_op,
   input  wire logic [31:0] req_address,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_last_char,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [4:0]  csr_bytes_per_record
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   hrse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   hrse_datapath #(
      .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_op               (req_op),
      .req_address          (req_address),
      .req_data_byte        (req_data_byte),
      .csr_valid            (csr_valid && csr_ready),
      .csr_bytes_per_record (csr_bytes_per_record),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_out_char         (rsp_out_char),
      .rsp_last_char        (rsp_last_char)
   );

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
module tb_top;
   import hrse_pkg::*;

   localparam logic [1:0] OP_IGNORED = 2'd3;
   localparam int DIR_ROWS      = 19;
   localparam int PHASE_ITEMS   = 13;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 150;
   localparam int CYCLE_LIMIT   = 300000;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] addr;
      logic [7:0]  data;
   } stim_row_type;

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } text_char_type;

   typedef logic [7:0] rec_buf_type [16];

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_op;
   logic [31:0] req_address;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_char;
   logic        rsp_last_char;
   logic        csr_valid;
   logic        csr_ready;
   logic [4:0]  csr_bytes_per_record;

   // encoder shadow state
   rec_buf_type rec_data;
   logic [4:0]  rec_fill;
   logic [31:0] rec_start;
   logic [15:0] upper_now;
   logic        upper_sent;
   logic [4:0]  bpr_shadow;

   logic [7:0]    line_buf [$];
   text_char_type pending_chars [$];

   stim_row_type dir_rows [DIR_ROWS];
   string        typed_text [DIR_ROWS];

   int          fail_count = 0;
   int          cycle_count = 0;
   bit          calm = 1'b0;
   bit          hold_request = 1'b0;

   hex_record_stream_encoder_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_address         (req_address),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_char        (rsp_out_char),
      .rsp_last_char       (rsp_last_char),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_bytes_per_record(csr_bytes_per_record)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Text predictor
   // ---------------------------------------------------------------
   function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
      return (nib > 4'd9) ? (8'd65 + 8'(nib - 4'd10)) : (8'd48 + 8'(nib));
   endfunction

   function automatic void append_char(input logic [7:0] c);
      line_buf.insert(line_buf.size(), c);
   endfunction

   function automatic void emit_byte_hex(input logic [7:0] v);
      append_char(nibble_ascii(v[7:4]));
      append_char(nibble_ascii(v[3:0]));
   endfunction

   function automatic void emit_record(input logic [7:0] count, input logic [15:0] offset,
                                       input logic [7:0] rtype, input rec_buf_type payload);
      logic [7:0] sum;
      int k;
      sum = count + offset[15:8] + offset[7:0] + rtype;
      append_char(CHAR_COLON);
      emit_byte_hex(count);
      emit_byte_hex(offset[15:8]);
      emit_byte_hex(offset[7:0]);
      emit_byte_hex(rtype);
      for (k = 0; k < int'(count) && k < 16; k++) begin
         emit_byte_hex(payload[k]);
         sum = sum + payload[k];
      end
      emit_byte_hex(8'd0 - sum);
      append_char(CHAR_NEWLINE);
   endfunction

   function automatic void close_open_record();
      if (rec_fill != 5'd0) begin
         emit_record(8'(rec_fill), rec_start[15:0], REC_TYPE_DATA, rec_data);
         rec_fill = 5'd0;
      end
   endfunction

   function automatic void clear_encoder_state();
      int k;
      for (k = 0; k < 16; k++) rec_data[k] = 8'h00;
      rec_fill   = 5'd0;
      rec_start  = 32'd0;
      upper_now  = 16'd0;
      upper_sent = 1'b0;
   endfunction

   function automatic void encode_item(input logic [1:0] op, input logic [31:0] addr,
                                       input logic [7:0] data);
      logic [4:0]  cap;
      logic [15:0] upper;
      logic        joins;
      rec_buf_type ela_buf;
      int          k;
      if (op == OP_END) begin
         close_open_record();
         emit_record(8'd0, 16'd0, REC_TYPE_EOF, rec_data);
         clear_encoder_state();
      end else if (op != OP_IGNORED) begin
         cap = bpr_shadow;
         if (cap == 5'd0) cap = 5'd1;
         if (cap > 5'd16) cap = 5'd16;
         upper = addr[31:16];
         joins = (op == OP_CONTINUE) && (rec_fill != 5'd0) && (rec_fill < cap)
                 && (addr == rec_start + 32'(rec_fill)) && (upper == rec_start[31:16]);
         if (!joins) begin
            close_open_record();
            if (upper != upper_now) begin
               // no address record while the upper half has stayed zero
               if (upper != 16'd0 || upper_sent) begin
                  for (k = 0; k < 16; k++) ela_buf[k] = 8'h00;
                  ela_buf[0] = upper[15:8];
                  ela_buf[1] = upper[7:0];
                  emit_record(ELA_COUNT, 16'd0, REC_TYPE_ELA, ela_buf);
                  upper_sent = 1'b1;
               end
               upper_now = upper;
            end
            rec_start = addr;
            rec_fill  = 5'd0;
         end
         if (rec_fill < 5'd16) begin
            rec_data[rec_fill[3:0]] = data;
            rec_fill = rec_fill + 5'd1;
         end
      end
   endfunction

   // ---------------------------------------------------------------
   // Result checker
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected transfer: out_char %02h last_char %0b",
                   rsp_out_char, rsp_last_char);
            fail_count++;
         end else begin
            want = pending_chars.pop_front();
            if (rsp_out_char !== want.ch) begin
               $error("out_char expected %02h actual %02h", want.ch, rsp_out_char);
               fail_count++;
            end
            if (rsp_last_char !== want.last) begin
               $error("last_char expected %0b actual %0b", want.last, rsp_last_char);
               fail_count++;
            end
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall <= !calm && ($urandom_range(99) < 26);
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   task automatic put_item(input logic [1:0] op, input logic [31:0] addr,
                           input logic [7:0] data, input string fixed_text);
      int i;
      text_char_type tc;
      while (!calm && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_address      <= addr;
      req_data_byte    <= data;
      do @(posedge clock); while (req_stall);
      encode_item(op, addr, data);
      if (fixed_text.len() != 0) begin
         line_buf.delete();
         for (i = 0; i < fixed_text.len(); i++) append_char(fixed_text[i]);
      end
      for (i = 0; i < line_buf.size(); i++) begin
         tc.ch   = line_buf[i];
         tc.last = (i == line_buf.size() - 1);
         pending_chars.insert(pending_chars.size(), tc);
      end
      line_buf.delete();
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (pending_chars.size() != 0) @(posedge clock);
      // an item with no text may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_bpr(input logic [4:0] value);
      csr_valid            <= 1'b1;
      csr_bytes_per_record <= value;
      do @(posedge clock); while (!csr_ready);
      bpr_shadow = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] fresh_address();
      logic [15:0] up;
      logic [15:0] lo;
      case ($urandom_range(4))
         0, 1:    up = 16'h0000;
         2:       up = upper_now;
         3:       up = $urandom_range(1) ? 16'h0001 : 16'hFFFF;
         default: up = 16'($urandom);
      endcase
      // low half near the top so runs cross into the next 64K page
      lo = ($urandom_range(3) == 0) ? (16'hFFF0 | 16'($urandom_range(15))) : 16'($urandom);
      return {up, lo};
   endfunction

   task automatic random_phase(input int target);
      int          count;
      int          pick;
      int          run_len;
      int          k;
      logic [31:0] addr;
      logic [1:0]  op;
      count = 0;
      while (count < target) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            run_len = ($urandom_range(3) == 0) ? $urandom_range(20, 12) : $urandom_range(6, 1);
            addr = fresh_address();
            for (k = 0; k < run_len; k++) begin
               op = OP_CONTINUE;
               if (k == 0 && $urandom_range(1)) op = OP_NEW_SECTION;
               if (k != 0 && $urandom_range(19) == 0) op = OP_NEW_SECTION;
               if (k != 0 && $urandom_range(19) == 0) addr = fresh_address();
               put_item(op, addr, 8'($urandom), "");
               addr = addr + 32'd1;
            end
            count += run_len;
         end else if (pick < 88) begin
            put_item(OP_END, $urandom, 8'($urandom), "");
            count++;
         end else if (pick < 94) begin
            put_item(OP_IGNORED, $urandom, 8'($urandom), "");
         end else begin
            op = 2'($urandom);
            put_item(op, $urandom, 8'($urandom), "");
            if (op != OP_IGNORED) count++;
         end
      end
   endtask

   initial begin
      logic [4:0] bpr_steps [7];
      int r;
      int p;

      req_valid            = 1'b0;
      req_op               = OP_CONTINUE;
      req_address          = 32'd0;
      req_data_byte        = 8'd0;
      rsp_stall            = 1'b0;
      csr_valid            = 1'b0;
      csr_bytes_per_record = 5'd0;
      clear_encoder_state();
      bpr_shadow = BPR_RESET;

      dir_rows = '{
         '{OP_END,         32'h0000_0000, 8'h00},
         '{OP_IGNORED,     32'hFFFF_FFFF, 8'hFF},
         '{OP_CONTINUE,    32'h0000_0000, 8'h00},
         '{OP_CONTINUE,    32'h0000_0001, 8'hFF},
         '{OP_CONTINUE,    32'h0000_0002, 8'h5A},
         '{OP_NEW_SECTION, 32'h0000_0003, 8'hA5},
         '{OP_CONTINUE,    32'h0000_1000, 8'h11},
         '{OP_CONTINUE,    32'h0000_FFFF, 8'h22},
         '{OP_CONTINUE,    32'h0001_0000, 8'h33},
         '{OP_CONTINUE,    32'h0001_0001, 8'h44},
         '{OP_CONTINUE,    32'h0000_0000, 8'h55},
         '{OP_END,         32'h0000_0000, 8'h00},
         '{OP_CONTINUE,    32'hFFFF_FFFF, 8'hFF},
         '{OP_END,         32'h0000_0000, 8'h00},
         '{OP_CONTINUE,    32'h1234_0000, 8'hC3},
         '{OP_IGNORED,     32'h1234_0001, 8'h3C},
         '{OP_CONTINUE,    32'h1234_0001, 8'h96},
         '{OP_NEW_SECTION, 32'hFFFF_0000, 8'h00},
         '{OP_END,         32'hFFFF_FFFF, 8'hFF}
      };
      typed_text = '{
         ":00000001FF\n", "", "", "", "", "", "", "", "", "", "", "",
         ":02000004FFFFFC\n", ":01FFFF00FF02\n:00000001FF\n",
         "", "", "", "", ""
      };
      bpr_steps = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd4, 5'($urandom_range(16, 1)), 5'd16};

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (r = 0; r < DIR_ROWS; r++) begin
         put_item(dir_rows[r].op, dir_rows[r].addr, dir_rows[r].data, typed_text[r]);
      end
      req_valid <= 1'b0;
      wait_drained();

      for (p = 0; p < 7; p++) begin
         write_bpr(bpr_steps[p]);
         calm = (p == 2);
         // long receiver hold-off while items keep coming
         if (p == 4) hold_request = 1'b1;
         random_phase(PHASE_ITEMS);
         req_valid <= 1'b0;
         wait_drained();
         calm = 1'b0;
      end

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
